### src/etrm_pkg.sv
// Package for the encoder turn tracking rpm meter.
// Holds the item types, the back end state type and fixed constants.
// No dependencies.
package etrm_pkg;

	localparam int RAW_ANGLE_W = 12;
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 24;
	localparam int RPM_W       = 32;
	localparam int TURNS_W     = 16;
	localparam int SF_W        = 30;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd100000;
	// rpm*16 scale: 60 s * 1e6 us * 16, times 2^12 counts folded into the divisor.
	localparam logic [SF_W-1:0] SPEED_FACTOR = 30'd960000000;

	// Register index decode (byte address bit 2).
	localparam logic REG_WINDOW_PERIOD = 1'b0;

	typedef struct packed {
		logic [RAW_ANGLE_W-1:0] raw_angle;
		logic [TIME_W-1:0]      time_us;
	} sample_t;

	typedef struct packed {
		logic signed [RPM_W-1:0]   rpm_x16;
		logic signed [TURNS_W-1:0] window_turns;
		logic [RAW_ANGLE_W-1:0]    end_angle;
		logic                      saturated;
	} result_t;

	typedef struct packed {
		logic signed [TURNS_W-1:0] window_turns;
		logic [RAW_ANGLE_W-1:0]    end_angle;
		logic                      turn_sat;
	} close_info_t;

	localparam int CLOSE_INFO_W = $bits(close_info_t);

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_CHK,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

### src/etrm_front.sv
// Front end of the rpm meter: accepts samples, tracks quadrants and turns,
// and decides when a window closes. Depends on etrm_pkg.
module etrm_front import etrm_pkg::*; #(
	parameter int ANGLE_BITS = 12,
	parameter int TURN_BITS  = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     sample_valid,
	output logic                                     sample_stall,
	input  sample_t                                  sample,
	input  logic [PERIOD_W-1:0]                      period,
	input  logic                                     q_full,
	output logic                                     push,
	output logic signed [TURN_BITS+ANGLE_BITS:0]     push_delta,
	output close_info_t                              push_info
);

	localparam int DW   = TURN_BITS + ANGLE_BITS + 1;
	localparam int TW16 = (TURN_BITS > TURNS_W) ? TURN_BITS : TURNS_W;

	localparam logic [ANGLE_BITS-1:0] Q1 = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] Q2 = Q1 << 1;
	localparam logic [ANGLE_BITS-1:0] Q3 = Q1 + Q2;
	localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};

	logic                          active_q;
	logic [TIME_W-1:0]             start_time_q;
	logic [ANGLE_BITS-1:0]         start_angle_q;
	logic [1:0]                    last_quad_q;
	logic signed [TURN_BITS-1:0]   turn_q;
	logic                          clamp_q;

	logic                          accept;
	logic [ANGLE_BITS-1:0]         angle;
	logic [1:0]                    quad;
	logic [PERIOD_W-1:0]           period_eff;
	logic [TIME_W-1:0]             elapsed;
	logic                          close;
	logic signed [TURN_BITS-1:0]   turn_nxt;
	logic                          clamp_nxt;
	logic signed [DW-1:0]          turn_ext;
	logic signed [DW-1:0]          turn_sh;
	logic signed [DW-1:0]          angle_ext;
	logic signed [DW-1:0]          start_ext;
	logic signed [TW16-1:0]        turn_wide;

	assign sample_stall = q_full;
	assign accept       = sample_valid && !q_full;
	assign angle        = ANGLE_BITS'(sample.raw_angle);

	always_comb begin
		if (angle <= Q1) begin
			quad = 2'd0;
		end else if (angle <= Q2) begin
			quad = 2'd1;
		end else if (angle <= Q3) begin
			quad = 2'd2;
		end else begin
			quad = 2'd3;
		end
	end

	// A zero period behaves as one microsecond.
	assign period_eff = (period == '0) ? PERIOD_W'(1) : period;
	assign elapsed    = sample.time_us - start_time_q;
	assign close      = elapsed > TIME_W'(period_eff);

	always_comb begin
		turn_nxt  = turn_q;
		clamp_nxt = clamp_q;
		if (quad == 2'd0 && last_quad_q == 2'd3) begin
			if (turn_q < TMAX) begin
				turn_nxt = turn_q + TURN_BITS'(1);
			end else begin
				clamp_nxt = 1'b1;
			end
		end else if (quad == 2'd3 && last_quad_q == 2'd0) begin
			if (turn_q > TMIN) begin
				turn_nxt = turn_q - TURN_BITS'(1);
			end else begin
				clamp_nxt = 1'b1;
			end
		end
	end

	assign turn_ext   = DW'(turn_nxt);
	assign turn_sh    = {turn_ext[DW-ANGLE_BITS-1:0], {ANGLE_BITS{1'b0}}};
	assign angle_ext  = DW'(angle);
	assign start_ext  = DW'(start_angle_q);
	assign push_delta = turn_sh + angle_ext - start_ext;

	assign turn_wide              = TW16'(turn_nxt);
	assign push_info.window_turns = turn_wide[TURNS_W-1:0];
	assign push_info.end_angle    = sample.raw_angle;
	assign push_info.turn_sat     = clamp_nxt;

	assign push = accept && active_q && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			start_time_q  <= '0;
			start_angle_q <= '0;
			last_quad_q   <= '0;
			turn_q        <= '0;
			clamp_q       <= 1'b0;
		end else if (accept) begin
			if (!active_q) begin
				active_q      <= 1'b1;
				start_time_q  <= sample.time_us;
				start_angle_q <= angle;
				last_quad_q   <= quad;
				turn_q        <= '0;
				clamp_q       <= 1'b0;
			end else begin
				last_quad_q <= quad;
				turn_q      <= turn_nxt;
				clamp_q     <= clamp_nxt;
				if (close) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

### src/etrm_queue.sv
// Short queue between the front and back ends of the rpm meter.
// Holds closed-window jobs as flat words. Depends on nothing else.
module etrm_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         nonempty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from an empty queue");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNTW'(1))
		else $error("queue count did not follow a push");

endmodule

### src/etrm_back.sv
// Back end of the rpm meter: scales the angle change by a partial-product
// multiply, divides by a restoring divider and saturates. Depends on etrm_pkg.
module etrm_back import etrm_pkg::*; #(
	parameter int ANGLE_BITS = 12,
	parameter int TURN_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_valid,
	input  logic signed [TURN_BITS+ANGLE_BITS:0] job_delta,
	input  close_info_t                          job_info,
	output logic                                 job_pop,
	input  logic [PERIOD_W-1:0]                  period,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output result_t                              result
);

	localparam int DW   = TURN_BITS + ANGLE_BITS + 1;
	localparam int CH   = 16;
	localparam int NCH  = (DW + CH - 1) / CH;
	localparam int PW   = NCH * CH;
	localparam int NW   = PW + SF_W;
	localparam int QW   = RPM_W + 1;
	localparam int DVW  = PERIOD_W + ANGLE_BITS;
	localparam int CW   = (NW > DVW + QW) ? NW : DVW + QW;
	localparam int CNTW = $clog2(QW + 1);

	back_state_t       state_q;
	back_state_t       state_nxt;
	logic [PW-1:0]     mag_q;
	logic              neg_q;
	close_info_t       info_q;
	logic [CW-1:0]     acc_q;
	logic [CW-1:0]     dvs_q;
	logic [QW-1:0]     quo_q;
	logic [CNTW-1:0]   cnt_q;
	logic              big_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [DW-1:0]        mag_in;
	logic [PERIOD_W-1:0]  period_eff;
	logic [CW-1:0]        dvs_init;
	logic [CH+SF_W-1:0]   pp;
	logic                 ge;
	logic                 res_load;
	logic                 sat_pos;
	logic                 sat_neg;
	result_t              res_nxt;

	assign mag_in     = job_delta[DW-1] ? DW'(-job_delta) : DW'(job_delta);
	assign period_eff = (period == '0) ? PERIOD_W'(1) : period;
	// Divisor is period * 2^ANGLE_BITS, first placed 33 bits up for the range check.
	assign dvs_init   = CW'({period_eff, {ANGLE_BITS{1'b0}}}) << QW;
	assign pp         = mag_q[PW-1 -: CH] * SPEED_FACTOR;
	assign ge         = acc_q >= dvs_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					state_nxt = BK_MUL;
				end
			end
			BK_MUL: begin
				if (cnt_q == '0) begin
					state_nxt = BK_CHK;
				end
			end
			BK_CHK: state_nxt = BK_DIV;
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!res_valid_q || !result_stall) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			BK_IDLE: job_pop = job_valid;
			BK_DONE: res_load = !res_valid_q || !result_stall;
			default: begin
				job_pop  = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				BK_IDLE: cnt_q <= CNTW'(NCH - 1);
				BK_CHK:  cnt_q <= CNTW'(QW - 1);
				BK_MUL,
				BK_DIV:  cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Multiply walks the magnitude one 16-bit chunk per cycle, top chunk first.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					mag_q  <= PW'(mag_in);
					neg_q  <= job_delta[DW-1];
					info_q <= job_info;
					acc_q  <= '0;
					dvs_q  <= dvs_init;
				end
			end
			BK_MUL: begin
				acc_q <= (acc_q << CH) + CW'(pp);
				mag_q <= mag_q << CH;
			end
			BK_CHK: begin
				big_q <= ge;
				dvs_q <= dvs_q >> 1;
				quo_q <= '0;
			end
			BK_DIV: begin
				if (ge) begin
					acc_q <= acc_q - dvs_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
				dvs_q <= dvs_q >> 1;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign sat_pos = big_q || quo_q[RPM_W] || quo_q[RPM_W-1];
	assign sat_neg = big_q || quo_q[RPM_W] || (quo_q[RPM_W-1] && (|quo_q[RPM_W-2:0]));

	always_comb begin
		res_nxt.window_turns = info_q.window_turns;
		res_nxt.end_angle    = info_q.end_angle;
		if (neg_q) begin
			res_nxt.rpm_x16   = sat_neg ? {1'b1, {(RPM_W-1){1'b0}}} : -quo_q[RPM_W-1:0];
			res_nxt.saturated = sat_neg || info_q.turn_sat;
		end else begin
			res_nxt.rpm_x16   = sat_pos ? {1'b0, {(RPM_W-1){1'b1}}} : quo_q[RPM_W-1:0];
			res_nxt.saturated = sat_pos || info_q.turn_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> cnt_q < CNTW'(QW))
		else $error("divider step count out of range");

	a_mul_to_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL && cnt_q == '0) |=> state_q == BK_CHK)
		else $error("multiply did not hand over to the range check");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> result_valid && state_q == BK_IDLE)
		else $error("result load did not show a valid item");

endmodule

### src/encoder_turn_tracking_rpm_meter_core.sv
// Top level of the encoder turn tracking rpm meter with its APB register.
// Depends on etrm_pkg, etrm_front, etrm_queue and etrm_back.
//
//   port group   | direction | handshake              | item
//   sample       | in        | sample_valid/stall     | raw_angle, time_us
//   result       | out       | result_valid/stall     | rpm_x16, window_turns, end_angle, saturated
//   apb          | in        | psel/penable, pready=1 | window_period_us at byte 0
//
// A sample is taken whenever the job queue (two entries) has room.
// A window close takes the back end through a chunked multiply, a range check
// and 33 divide steps.
// Reset clears the window tracking, the queue and the back end; no clearing pass.
// A stalled result holds in the output register; the back end keeps working until its next result waits.
module encoder_turn_tracking_rpm_meter_core import etrm_pkg::*; #(
	parameter int ANGLE_BITS = 12,
	parameter int TURN_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DW = TURN_BITS + ANGLE_BITS + 1;
	localparam int QW = DW + CLOSE_INFO_W;

	logic [PERIOD_W-1:0]   period_q;
	logic                  q_full;
	logic                  q_nonempty;
	logic                  push;
	logic signed [DW-1:0]  push_delta;
	close_info_t           push_info;
	logic                  pop;
	logic [QW-1:0]         pop_data;
	close_info_t           pop_info;
	logic signed [DW-1:0]  pop_delta;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_PERIOD) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_WINDOW_PERIOD) ? 32'(period_q) : '0;

	etrm_front #(
		.ANGLE_BITS (ANGLE_BITS),
		.TURN_BITS  (TURN_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.period       (period_q),
		.q_full       (q_full),
		.push         (push),
		.push_delta   (push_delta),
		.push_info    (push_info)
	);

	etrm_queue #(
		.W     (QW),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_delta, push_info}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (q_nonempty)
	);

	assign pop_delta = pop_data[QW-1 -: DW];
	assign pop_info  = pop_data[CLOSE_INFO_W-1:0];

	etrm_back #(
		.ANGLE_BITS (ANGLE_BITS),
		.TURN_BITS  (TURN_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_nonempty),
		.job_delta    (pop_delta),
		.job_info     (pop_info),
		.job_pop      (pop),
		.period       (period_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
